@@ rtl/ictf_pkg.sv @@
// Shared widths, register indexes, item types and the CORDIC angle table of the tilt filter.
package ictf_pkg;

  localparam int AXIS_W     = 16;
  localparam int RATE_W     = 17;
  localparam int TS_W       = 32;
  localparam int ANG_W      = 32;
  localparam int OFF_W      = 25;
  localparam int BIAS_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_OFF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_OFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Z    = 3'd4;

  localparam int CORDIC_ITER_DEF = 16;
  localparam int ANG_TAB_LEN     = 24;
  localparam int ANG_IDX_W       = 5;
  localparam int CORDIC_FRAC     = 16;
  localparam int CX_W            = 36;
  localparam int CZ_W            = 33;
  localparam int TILT_W          = 26;

  // atan(2^-i) in units of 2^-24 degree.
  localparam logic signed [31:0] ATAN_TAB [ANG_TAB_LEN] = '{
    32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
    32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
    32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
    32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
    32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
    32'sd917,       32'sd458,       32'sd229,       32'sd115
  };

  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
    logic signed [AXIS_W-1:0] az;
    logic signed [RATE_W-1:0] rx;
    logic signed [RATE_W-1:0] ry;
    logic signed [RATE_W-1:0] rz;
    logic [TS_W-1:0]          dt;
  } item_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] roll_off;
    logic signed [OFF_W-1:0] pitch_off;
  } offs_t;

endpackage

@@ rtl/ictf_if.sv @@
// Valid/ready channel interfaces for samples, results and register writes.
interface ictf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ictf_pkg::AXIS_W-1:0]  accel_x;
  logic signed [ictf_pkg::AXIS_W-1:0]  accel_y;
  logic signed [ictf_pkg::AXIS_W-1:0]  accel_z;
  logic signed [ictf_pkg::AXIS_W-1:0]  rate_x;
  logic signed [ictf_pkg::AXIS_W-1:0]  rate_y;
  logic signed [ictf_pkg::AXIS_W-1:0]  rate_z;
  logic [ictf_pkg::TS_W-1:0]           timestamp_us;
  modport source (output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  timestamp_us, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                  timestamp_us, output ready);
endinterface

interface ictf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ictf_pkg::ANG_W-1:0]  roll;
  logic signed [ictf_pkg::ANG_W-1:0]  pitch;
  logic signed [ictf_pkg::ANG_W-1:0]  yaw;
  modport source (output valid, roll, pitch, yaw, input ready);
  modport sink   (input valid, roll, pitch, yaw, output ready);
endinterface

interface ictf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ictf_pkg::CFG_IDX_W-1:0]      index;
  logic [ictf_pkg::CFG_DATA_W-1:0]     wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

@@ rtl/ictf_front.sv @@
// Front end: register file, sample intake, gyro bias removal and timestamp delta.
module ictf_front (
  input  logic            clk,
  input  logic            rst_n,
  ictf_in_if.sink         in_ch,
  ictf_cfg_if.sink        cfg_ch,
  output logic            q_push,
  output ictf_pkg::item_t q_wdata,
  input  logic            q_full,
  output ictf_pkg::offs_t offs
);
  import ictf_pkg::*;

  logic [TS_W-1:0]          last_ts_r;
  logic signed [BIAS_W-1:0] bias_x_r;
  logic signed [BIAS_W-1:0] bias_y_r;
  logic signed [BIAS_W-1:0] bias_z_r;
  logic signed [OFF_W-1:0]  roll_off_r;
  logic signed [OFF_W-1:0]  pitch_off_r;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign q_push       = in_ch.valid && !q_full;

  always_comb begin
    q_wdata.ax = in_ch.accel_x;
    q_wdata.ay = in_ch.accel_y;
    q_wdata.az = in_ch.accel_z;
    q_wdata.rx = RATE_W'($signed(in_ch.rate_x)) - RATE_W'($signed(bias_x_r));
    q_wdata.ry = RATE_W'($signed(in_ch.rate_y)) - RATE_W'($signed(bias_y_r));
    q_wdata.rz = RATE_W'($signed(in_ch.rate_z)) - RATE_W'($signed(bias_z_r));
    // The delta wraps modulo 2^32, so a backwards timestamp gives a huge delta.
    q_wdata.dt = in_ch.timestamp_us - last_ts_r;
    offs.roll_off  = roll_off_r;
    offs.pitch_off = pitch_off_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ts_r   <= '0;
      bias_x_r    <= '0;
      bias_y_r    <= '0;
      bias_z_r    <= '0;
      roll_off_r  <= '0;
      pitch_off_r <= '0;
    end else begin
      if (q_push) begin
        last_ts_r <= in_ch.timestamp_us;
      end
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_ROLL_OFF:  roll_off_r  <= cfg_ch.wdata[OFF_W-1:0];
          CFG_PITCH_OFF: pitch_off_r <= cfg_ch.wdata[OFF_W-1:0];
          CFG_BIAS_X:    bias_x_r    <= cfg_ch.wdata[BIAS_W-1:0];
          CFG_BIAS_Y:    bias_y_r    <= cfg_ch.wdata[BIAS_W-1:0];
          CFG_BIAS_Z:    bias_z_r    <= cfg_ch.wdata[BIAS_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/ictf_fifo.sv @@
// Short queue that decouples sample intake from the compute back end.
module ictf_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ictf_pkg::item_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output ictf_pkg::item_t rdata
);
  import ictf_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  item_t            mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full  = (cnt_r == CNT_W'(Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/ictf_cordic.sv @@
// Two-lane iterative CORDIC vectoring unit producing roll and pitch tilt angles.
module ictf_cordic #(
  parameter int ITER = ictf_pkg::CORDIC_ITER_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [ictf_pkg::AXIS_W-1:0]  ax,
  input  logic signed [ictf_pkg::AXIS_W-1:0]  ay,
  input  logic signed [ictf_pkg::AXIS_W-1:0]  az,
  output logic                                done,
  output logic signed [ictf_pkg::TILT_W-1:0]  roll_ang,
  output logic signed [ictf_pkg::TILT_W-1:0]  pitch_ang
);
  import ictf_pkg::*;

  localparam int NL    = 2;
  localparam int MAG_W = AXIS_W + 1;
  localparam logic [1:0] P_DEN = 2'd0;
  localparam logic [1:0] P_NUM = 2'd1;
  localparam logic [1:0] P_ANG = 2'd2;

  logic                   busy_r;
  logic                   done_r;
  logic [1:0]             pass_r;
  logic [ANG_IDX_W-1:0]   iter_r;
  logic signed [CX_W-1:0] x_r     [NL];
  logic signed [CX_W-1:0] y_r     [NL];
  logic signed [CZ_W-1:0] z_r     [NL];
  logic signed [CX_W-1:0] den_r   [NL];
  logic [MAG_W-1:0]       nmag_r  [NL];
  logic                   nneg_r  [NL];
  logic                   nzero_r [NL];
  logic                   zvec_r  [NL];
  logic signed [TILT_W-1:0] ang_r [NL];

  logic signed [CX_W-1:0] x_nxt [NL];
  logic signed [CX_W-1:0] y_nxt [NL];
  logic signed [CZ_W-1:0] z_nxt [NL];
  logic signed [CX_W-1:0] nm_w  [NL];
  logic signed [CZ_W-1:0] zr_w  [NL];
  logic                   last_w;

  function automatic logic [MAG_W-1:0] mag(input logic signed [AXIS_W-1:0] v);
    logic signed [MAG_W-1:0] e;
    e = MAG_W'(v);
    return (e < 0) ? $unsigned(-e) : $unsigned(e);
  endfunction

  function automatic logic signed [CX_W-1:0] scaled(input logic [MAG_W-1:0] m);
    return $signed(CX_W'({m, {CORDIC_FRAC{1'b0}}}));
  endfunction

  assign last_w    = busy_r && (iter_r == ANG_IDX_W'(ITER - 1));
  assign done      = done_r;
  assign roll_ang  = ang_r[0];
  assign pitch_ang = ang_r[1];

  always_comb begin
    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;
    for (int l = 0; l < NL; l++) begin
      xs = x_r[l] >>> iter_r;
      ys = y_r[l] >>> iter_r;
      if (y_r[l] > 0) begin
        x_nxt[l] = x_r[l] + ys;
        y_nxt[l] = y_r[l] - xs;
        z_nxt[l] = z_r[l] + CZ_W'(ATAN_TAB[iter_r]);
      end else begin
        x_nxt[l] = x_r[l] - ys;
        y_nxt[l] = y_r[l] + xs;
        z_nxt[l] = z_r[l] - CZ_W'(ATAN_TAB[iter_r]);
      end
      // The numerator magnitude takes the sign of the raw numerator back, inverted for the pitch lane.
      if (nzero_r[l]) begin
        nm_w[l] = '0;
      end else if (nneg_r[l]) begin
        nm_w[l] = -x_nxt[l];
      end else begin
        nm_w[l] = x_nxt[l];
      end
      zr_w[l] = z_nxt[l] + CZ_W'(128);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      pass_r <= P_DEN;
      iter_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      pass_r <= P_DEN;
      iter_r <= '0;
    end else if (last_w) begin
      iter_r <= '0;
      unique case (pass_r)
        P_DEN:   pass_r <= P_NUM;
        P_NUM:   pass_r <= P_ANG;
        default: begin
          pass_r <= P_DEN;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      endcase
    end else if (busy_r) begin
      iter_r <= iter_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r[0]     <= scaled(mag(ax));
      y_r[0]     <= scaled(mag(az));
      nmag_r[0]  <= mag(ay);
      nneg_r[0]  <= ay < 0;
      nzero_r[0] <= ay == '0;
      x_r[1]     <= scaled(mag(ay));
      y_r[1]     <= scaled(mag(az));
      nmag_r[1]  <= mag(ax);
      nneg_r[1]  <= ax > 0;
      nzero_r[1] <= ax == '0;
      for (int l = 0; l < NL; l++) begin
        z_r[l] <= '0;
      end
    end else if (last_w) begin
      for (int l = 0; l < NL; l++) begin
        z_r[l] <= '0;
        unique case (pass_r)
          P_DEN: begin
            den_r[l] <= x_nxt[l];
            x_r[l]   <= scaled(nmag_r[l]);
            y_r[l]   <= '0;
          end
          P_NUM: begin
            x_r[l]    <= den_r[l];
            y_r[l]    <= nm_w[l];
            zvec_r[l] <= (den_r[l] == '0) && nzero_r[l];
          end
          default: begin
            ang_r[l] <= zvec_r[l] ? '0 : TILT_W'(zr_w[l] >>> 8);
          end
        endcase
      end
    end else if (busy_r) begin
      for (int l = 0; l < NL; l++) begin
        x_r[l] <= x_nxt[l];
        y_r[l] <= y_nxt[l];
        z_r[l] <= z_nxt[l];
      end
    end
  end

endmodule

@@ rtl/ictf_back.sv @@
// Back end: gyro integration, reciprocal constant dividers, fusion and the result register.
module ictf_back #(
  parameter int ITER = ictf_pkg::CORDIC_ITER_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  ictf_pkg::item_t q_rdata,
  output logic            q_pop,
  input  ictf_pkg::offs_t offs,
  ictf_out_if.source      out_ch
);
  import ictf_pkg::*;

  localparam int NL         = 3;
  localparam int DVD_W      = 60;
  localparam int REM_W      = 24;
  localparam int QUO_W      = 40;
  localparam int PROD_W     = 50;
  localparam int PP_W       = 64;
  localparam int MID_W      = 65;
  localparam int ACC_W      = 27;
  localparam int SUM_W      = 38;
  localparam int SAT_W      = 48;
  localparam int CNT_W      = 2;
  localparam int FIX_STEPS  = 2;
  localparam int GYRO_SHIFT = 10;
  localparam logic [REM_W-1:0] GYRO_DEN  = 24'd2046875;
  localparam logic [REM_W-1:0] FUSE_DEN  = 24'd25;
  localparam logic [PP_W-1:0]  GYRO_RCP  = 64'hFFFF_FFFF_FFFF_FFFF / 64'd2046875;
  localparam logic [PP_W-1:0]  FUSE_RCP  = 64'hFFFF_FFFF_FFFF_FFFF / 64'd25;
  localparam logic [DVD_W-1:0] GYRO_HALF = 60'd1023437;
  localparam logic [DVD_W-1:0] FUSE_HALF = 60'd12;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_GABS  = 4'd2;
  localparam logic [3:0] S_GLD   = 4'd3;
  localparam logic [3:0] S_DPP   = 4'd4;
  localparam logic [3:0] S_DQ    = 4'd5;
  localparam logic [3:0] S_DREM  = 4'd6;
  localparam logic [3:0] S_DFIX  = 4'd7;
  localparam logic [3:0] S_INTEG = 4'd8;
  localparam logic [3:0] S_WAIT  = 4'd9;
  localparam logic [3:0] S_FABS  = 4'd10;
  localparam logic [3:0] S_FLD   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]               state_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     fuse_r;
  logic signed [RATE_W-1:0] rate_r [NL];
  logic [TS_W-1:0]          dt_r;
  logic signed [PROD_W-1:0] prod_r [NL];
  logic signed [SUM_W-1:0]  sum_r  [2];
  logic [DVD_W-1:0]         dvd_r  [NL];
  logic [PP_W-1:0]          pp_hh_r [NL];
  logic [PP_W-1:0]          pp_hl_r [NL];
  logic [PP_W-1:0]          pp_lh_r [NL];
  logic [REM_W-1:0]         rem_r  [NL];
  logic [QUO_W-1:0]         quo_r  [NL];
  logic                     neg_r  [NL];
  logic signed [ANG_W-1:0]  gang_r [NL];
  logic                     out_valid_r;
  logic signed [ANG_W-1:0]  roll_r;
  logic signed [ANG_W-1:0]  pitch_r;
  logic signed [ANG_W-1:0]  yaw_r;

  logic [REM_W-1:0]         dv_w;
  logic [PP_W-1:0]          rcp_w;
  logic [QUO_W-1:0]         qest_w  [NL];
  logic [REM_W-1:0]         rem_w   [NL];
  logic signed [QUO_W:0]    sval    [NL];
  logic signed [SUM_W-1:0]  sum_w   [2];
  logic                     cdc_done;
  logic signed [TILT_W-1:0] tilt_w  [2];

  function automatic logic signed [ANG_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    if (v > SAT_W'(32'sh7fffffff)) begin
      return 32'sh7fffffff;
    end else if (v < SAT_W'(32'sh80000000)) begin
      return 32'sh80000000;
    end
    return v[ANG_W-1:0];
  endfunction

  ictf_cordic #(.ITER(ITER)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (q_pop),
    .ax        (q_rdata.ax),
    .ay        (q_rdata.ay),
    .az        (q_rdata.az),
    .done      (cdc_done),
    .roll_ang  (tilt_w[0]),
    .pitch_ang (tilt_w[1])
  );

  assign q_pop        = (state_r == S_IDLE) && q_valid;
  assign out_ch.valid = out_valid_r;
  assign out_ch.roll  = roll_r;
  assign out_ch.pitch = pitch_r;
  assign out_ch.yaw   = yaw_r;

  assign dv_w  = fuse_r ? FUSE_DEN : GYRO_DEN;
  assign rcp_w = fuse_r ? FUSE_RCP : GYRO_RCP;

  // Division by a constant: the quotient estimate from the reciprocal drops the low
  // partial product, so it is short by at most two, and two compare and subtract steps
  // on the remainder finish it. The remainder stays below three divisors, so its low
  // bits alone are exact.
  always_comb begin
    logic [MID_W-1:0] mid;
    for (int l = 0; l < NL; l++) begin
      mid       = MID_W'(pp_hl_r[l]) + MID_W'(pp_lh_r[l]);
      qest_w[l] = QUO_W'(pp_hh_r[l] + PP_W'(mid >> 32));
      rem_w[l]  = dvd_r[l][REM_W-1:0] - quo_r[l][REM_W-1:0] * dv_w;
      sval[l]   = neg_r[l] ? -$signed({1'b0, quo_r[l]}) : $signed({1'b0, quo_r[l]});
    end
  end

  // 24*g + a, the numerator of the 0.96/0.04 mix over 25.
  always_comb begin
    logic signed [ACC_W-1:0] a;
    logic signed [SUM_W-1:0] g;
    for (int l = 0; l < 2; l++) begin
      a = ACC_W'(tilt_w[l]) -
          ACC_W'($signed((l == 0) ? offs.roll_off : offs.pitch_off));
      g = SUM_W'(gang_r[l]);
      sum_w[l] = (g <<< 4) + (g <<< 3) + SUM_W'(a);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      fuse_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < NL; l++) begin
        gang_r[l] <= '0;
      end
    end else begin
      if ((state_r == S_OUT) && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            rate_r[0] <= q_rdata.rx;
            rate_r[1] <= q_rdata.ry;
            rate_r[2] <= q_rdata.rz;
            dt_r      <= q_rdata.dt;
            state_r   <= S_MUL;
          end
        end
        S_MUL: begin
          for (int l = 0; l < NL; l++) begin
            prod_r[l] <= PROD_W'(rate_r[l]) * PROD_W'($signed({1'b0, dt_r}));
          end
          state_r <= S_GABS;
        end
        S_GABS: begin
          for (int l = 0; l < NL; l++) begin
            neg_r[l] <= prod_r[l][PROD_W-1];
            dvd_r[l] <= DVD_W'($unsigned(prod_r[l][PROD_W-1] ? -prod_r[l] : prod_r[l]));
          end
          state_r <= S_GLD;
        end
        S_GLD: begin
          for (int l = 0; l < NL; l++) begin
            dvd_r[l] <= (dvd_r[l] << GYRO_SHIFT) + GYRO_HALF;
          end
          fuse_r  <= 1'b0;
          state_r <= S_DPP;
        end
        S_DPP: begin
          for (int l = 0; l < NL; l++) begin
            pp_hh_r[l] <= PP_W'(dvd_r[l][DVD_W-1:32]) * PP_W'(rcp_w[PP_W-1:32]);
            pp_hl_r[l] <= PP_W'(dvd_r[l][DVD_W-1:32]) * PP_W'(rcp_w[31:0]);
            pp_lh_r[l] <= PP_W'(dvd_r[l][31:0]) * PP_W'(rcp_w[PP_W-1:32]);
          end
          state_r <= S_DQ;
        end
        S_DQ: begin
          for (int l = 0; l < NL; l++) begin
            quo_r[l] <= qest_w[l];
          end
          state_r <= S_DREM;
        end
        S_DREM: begin
          for (int l = 0; l < NL; l++) begin
            rem_r[l] <= rem_w[l];
          end
          cnt_r   <= CNT_W'(FIX_STEPS - 1);
          state_r <= S_DFIX;
        end
        S_DFIX: begin
          for (int l = 0; l < NL; l++) begin
            if (rem_r[l] >= dv_w) begin
              quo_r[l] <= quo_r[l] + 1'b1;
              rem_r[l] <= rem_r[l] - dv_w;
            end
          end
          if (cnt_r == '0) begin
            state_r <= fuse_r ? S_OUT : S_INTEG;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_INTEG: begin
          for (int l = 0; l < NL; l++) begin
            gang_r[l] <= sat32(SAT_W'(gang_r[l]) + SAT_W'(sval[l]));
          end
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (cdc_done) begin
            sum_r[0] <= sum_w[0];
            sum_r[1] <= sum_w[1];
            state_r  <= S_FABS;
          end
        end
        S_FABS: begin
          for (int l = 0; l < 2; l++) begin
            neg_r[l] <= sum_r[l][SUM_W-1];
            dvd_r[l] <= DVD_W'($unsigned(sum_r[l][SUM_W-1] ? -sum_r[l] : sum_r[l]));
          end
          state_r <= S_FLD;
        end
        S_FLD: begin
          for (int l = 0; l < NL; l++) begin
            dvd_r[l] <= dvd_r[l] + FUSE_HALF;
          end
          fuse_r  <= 1'b1;
          state_r <= S_DPP;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            roll_r  <= sat32(SAT_W'(sval[0]));
            pitch_r <= sat32(SAT_W'(sval[1]));
            yaw_r   <= gang_r[2];
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/imu_complementary_tilt_filter.sv @@
// Top level of the complementary roll/pitch filter with yaw integration.
// Each sample beat yields one result beat of roll, pitch and yaw in Q16.16 degrees. The back end
// takes one sample at a time and pops the next only when it is back in its idle state: the
// two-lane CORDIC unit runs three vectoring passes of CORDIC_ITERATIONS iterations each while
// the gyro increment path runs alongside it, and the fusion divide by 25 follows once the CORDIC
// finishes. A two-entry queue takes samples while the back end works, and the result register
// holds a finished result until it is taken; a stalled result holds the back end in its last
// state. Register writes are accepted every cycle and take effect at once.
module imu_complementary_tilt_filter #(
  parameter int CORDIC_ITERATIONS = ictf_pkg::CORDIC_ITER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ictf_in_if.sink     in_ch,
  ictf_out_if.source  out_ch,
  ictf_cfg_if.sink    cfg_ch
);
  import ictf_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  item_t q_wdata;
  item_t q_rdata;
  offs_t offs;

  ictf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg_ch  (cfg_ch),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .offs    (offs)
  );

  ictf_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  ictf_back #(.ITER(CORDIC_ITERATIONS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .offs    (offs),
    .out_ch  (out_ch)
  );

endmodule

@@ rtl/ictf_checker.sv @@
// Port-level assertions for the tilt filter and the bind that attaches them.
module ictf_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [ictf_pkg::ANG_W-1:0]  out_roll,
  input logic signed [ictf_pkg::ANG_W-1:0]  out_pitch,
  input logic signed [ictf_pkg::ANG_W-1:0]  out_yaw
);
  import ictf_pkg::*;

  // Reset empties the queue and the result register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear result and queue");

  // The queue only fills on a sample beat, so ready can only drop after one.
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("input ready dropped without a sample beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before its beat");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_roll) && $stable(out_pitch) && $stable(out_yaw))
    else $error("stalled result changed");

endmodule

bind imu_complementary_tilt_filter ictf_checker u_ictf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_roll  (out_ch.roll),
  .out_pitch (out_ch.pitch),
  .out_yaw   (out_ch.yaw)
);
